>>> hw/rtl/sdf_pkg.sv
// shared constants and types for the signed decimal formatter
// no dependencies
package sdf_pkg;

	localparam int unsigned MAX_WIDTH  = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned BIN_W      = 32;
	localparam int unsigned LEN_W      = 6;
	// two binary bits are folded in per step
	localparam int unsigned CONV_STEPS = BIN_W / 2;
	localparam int unsigned STEP_W     = $clog2(CONV_STEPS);

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	// one job handed from the sequencer to the character emitter
	typedef struct packed {
		logic             negative;
		logic [LEN_W-1:0] req_width;
		logic [7:0]       fill;
		logic [BCD_W-1:0] bcd;
	} job_t;

endpackage

>>> hw/rtl/sdf_bcd_conv.sv
// iterative binary to bcd converter, shift and add-3, two bits per cycle
// depends on sdf_pkg
module sdf_bcd_conv
	import sdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] bin,
	output logic             done,
	output logic [BCD_W-1:0] bcd
);

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BCD_W-1:0]  adj1;
	logic [BCD_W-1:0]  step1;
	logic [BCD_W-1:0]  adj2;
	logic [BCD_W-1:0]  step2;

	function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] d);
		logic [BCD_W-1:0] r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = d[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	always_comb begin
		adj1  = add3(bcd_q);
		step1 = {adj1[BCD_W-2:0], bin_q[BIN_W-1]};
		adj2  = add3(step1);
		step2 = {adj2[BCD_W-2:0], bin_q[BIN_W-2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CONV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-3:0], 2'b00};
			bcd_q <= step2;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

>>> hw/rtl/sdf_emitter.sv
// character sequencer: padding, sign and digits, one word per cycle while out_ready is high
// depends on sdf_pkg
module sdf_emitter
	import sdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  job_t             job,
	output logic             finished,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_char,
	output logic             last,
	output logic [LEN_W-1:0] field_length
);

	logic             active_q;
	logic             ov_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic [LEN_W-1:0] total_q;
	logic [LEN_W-1:0] pad_q;
	logic [LEN_W-1:0] k_q;
	logic             neg_q;
	logic [7:0]       fill_q;
	logic [BCD_W-1:0] bcd_q;

	logic [3:0]       ndig;
	logic [3:0]       text_len;
	logic [LEN_W-1:0] req_sat;
	logic [LEN_W-1:0] total;
	logic             load;
	logic [LEN_W-1:0] didx;
	logic [7:0]       next_char;

	// setup of the run from the converted digits
	always_comb begin
		ndig = 4'd1;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (job.bcd[4*i +: 4] != 4'd0) begin
				ndig = 4'(i + 1);
			end
		end
		text_len = ndig + {3'b000, job.negative};
		req_sat  = (job.req_width > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : job.req_width;
		total    = (req_sat > {2'b00, text_len}) ? req_sat : {2'b00, text_len};
	end

	assign load = active_q && (!ov_q || out_ready);
	assign didx = total_q - 1'b1 - k_q;

	always_comb begin
		priority if (k_q < pad_q) begin
			next_char = fill_q;
		end else if (neg_q && (k_q == pad_q)) begin
			next_char = ASCII_MINUS;
		end else begin
			next_char = ASCII_ZERO | {4'h0, bcd_q[{didx[3:0], 2'b00} +: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ov_q     <= 1'b0;
			k_q      <= '0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (load) begin
				k_q <= k_q + 1'b1;
				if (k_q == total_q - 1'b1) begin
					active_q <= 1'b0;
				end
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			total_q <= total;
			pad_q   <= total - {2'b00, text_len};
			neg_q   <= job.negative;
			fill_q  <= job.fill;
			bcd_q   <= job.bcd;
		end
		if (load) begin
			char_q <= next_char;
			last_q <= (k_q == total_q - 1'b1);
		end
	end

	assign finished     = ov_q && out_ready && last_q;
	assign out_valid    = ov_q;
	assign out_char     = char_q;
	assign last         = last_q;
	assign field_length = total_q;

endmodule

>>> hw/rtl/signed_decimal_formatter.sv
// signed decimal formatter: signed 32-bit value to padded ascii text
// first word offered after the bcd conversion, the run setup and the register of the first word,
// then one word per cycle while out_ready is high
// the conversion folds two bits per cycle through add-3 units chained in series
// reset (arst_n, asynchronous, active low) clears the sequencer and output valid
// depends on sdf_pkg, sdf_bcd_conv, sdf_emitter
module signed_decimal_formatter
	import sdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic signed [31:0] value,
	input  logic [LEN_W-1:0] min_width,
	input  logic [7:0]       fill_char,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_char,
	output logic             last,
	output logic [LEN_W-1:0] field_length
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic             neg_q;
	logic [LEN_W-1:0] req_q;
	logic [7:0]       fill_q;
	logic             in_acc;
	logic [BIN_W-1:0] raw;
	logic [BIN_W-1:0] mag;
	logic             conv_done;
	logic [BCD_W-1:0] conv_bcd;
	logic             emit_done;
	job_t             job;

	// one word in flight at a time; ready only between runs
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// magnitude taken as unsigned, so the most negative value comes out right
	assign raw = value;
	assign mag = raw[BIN_W-1] ? (~raw + 1'b1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// back to idle once the final word of the run is taken
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// job fields held while the digits are worked out
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q  <= raw[BIN_W-1];
			req_q  <= min_width;
			fill_q <= fill_char;
		end
	end

	sdf_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.bin    (mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	assign job = '{negative: neg_q, req_width: req_q, fill: fill_q, bcd: conv_bcd};

	sdf_emitter u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (conv_done),
		.job          (job),
		.finished     (emit_done),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.last         (last),
		.field_length (field_length)
	);

	// no output word outside the emit phase
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EMIT))
		else $error("output word outside emit phase");

	// a taken word that is not the last is followed at once by the next of the same run
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=>
		(out_valid && (field_length == $past(field_length))))
		else $error("run broken or length changed");

	// after the final word the block drops valid and is ready for new input
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> (!out_valid && in_ready))
		else $error("run did not end cleanly");

	// field length always covers at least one character
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (field_length != '0))
		else $error("zero field length");

endmodule
